### rtl/x10rf_pkg.sv
`default_nettype none

package x10rf_pkg;

   // frame layout
   localparam int FRAME_BITS = 40;
   localparam int SYM_COUNT_W = 6;
   localparam logic [SYM_COUNT_W-1:0] SYM_LAST = 6'd41;

   localparam logic [7:0] HEADER_HI = 8'hD5;
   localparam logic [7:0] HEADER_LO = 8'hAA;
   localparam logic [7:0] FOOTER = 8'hAD;
   localparam logic [7:0] OFF_FLAG = 8'h20;
   localparam logic [7:0] HIGH_UNIT_FLAG = 8'h04;

   // register map and reset values
   localparam int CSR_ADDR_W = 3;
   localparam int HOLD_W = 24;
   localparam logic [HOLD_W-1:0] BIT_HOLD_RESET = 24'd50000;
   localparam logic [HOLD_W-1:0] READY_HOLD_RESET = 24'd1500000;

   typedef enum logic {
      CSR_BIT_HOLD = 1'b0,
      CSR_READY_HOLD = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      CMD_OFF = 3'd0,
      CMD_ON = 3'd1,
      CMD_DIM = 3'd2,
      CMD_BRIGHT = 3'd3,
      CMD_ALL_LIGHTS_ON = 3'd4,
      CMD_ALL_LIGHTS_OFF = 3'd5,
      CMD_ALL_UNITS_OFF = 3'd6,
      CMD_UNDEFINED = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_READY = 2'd0,
      KIND_DATA = 2'd1,
      KIND_PAUSE = 2'd2
   } kind_type;

   typedef enum logic {
      SER_IDLE = 1'b0,
      SER_SEND = 1'b1
   } ser_state_type;

   // frame load request from the builder to the shifter
   typedef struct packed {
      logic go;
      logic [FRAME_BITS-1:0] frame;
   } load_type;

   function automatic logic [7:0] house_code(input logic [3:0] house);
      logic [7:0] code;
      case (house)
         4'd0: code = 8'h60;
         4'd1: code = 8'h70;
         4'd2: code = 8'h40;
         4'd3: code = 8'h50;
         4'd4: code = 8'h80;
         4'd5: code = 8'h90;
         4'd6: code = 8'hA0;
         4'd7: code = 8'hB0;
         4'd8: code = 8'hE0;
         4'd9: code = 8'hF0;
         4'd10: code = 8'hC0;
         4'd11: code = 8'hD0;
         4'd12: code = 8'h00;
         4'd13: code = 8'h10;
         4'd14: code = 8'h20;
         4'd15: code = 8'h30;
         default: code = 8'h00;
      endcase
      return code;
   endfunction

   function automatic logic [7:0] unit_code(input logic [2:0] unit);
      logic [7:0] code;
      case (unit)
         3'd0: code = 8'h00;
         3'd1: code = 8'h10;
         3'd2: code = 8'h08;
         3'd3: code = 8'h18;
         3'd4: code = 8'h40;
         3'd5: code = 8'h50;
         3'd6: code = 8'h48;
         3'd7: code = 8'h58;
         default: code = 8'h00;
      endcase
      return code;
   endfunction

   function automatic logic [7:0] fixed_code(input cmd_type cmd);
      logic [7:0] code;
      case (cmd)
         CMD_DIM: code = 8'h98;
         CMD_BRIGHT: code = 8'h88;
         CMD_ALL_LIGHTS_ON: code = 8'h90;
         CMD_ALL_LIGHTS_OFF: code = 8'hA0;
         CMD_ALL_UNITS_OFF: code = 8'h80;
         default: code = 8'h00;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

### rtl/x10rf_frame_build.sv
`default_nettype none

module x10rf_frame_build
   import x10rf_pkg::*;
(
   input wire logic take,
   input wire logic [3:0] house_index,
   input wire logic [4:0] unit_number,
   input wire logic [2:0] cmd,
   output load_type load
);

   logic [3:0] unit_idx;
   logic [7:0] house_byte;
   logic [7:0] cmd_byte;
   cmd_type cmd_code;

   // unit 1..16 maps to index 0..15, wrapping out-of-range values
   assign unit_idx = 4'(unit_number + 5'd15);
   assign cmd_code = cmd_type'(cmd);

   // assemble house and command bytes
   always_comb begin
      house_byte = house_code(house_index);
      cmd_byte = fixed_code(cmd_code);
      if (cmd_code == CMD_OFF || cmd_code == CMD_ON) begin
         if (unit_idx[3]) begin
            house_byte = house_byte | HIGH_UNIT_FLAG;
         end
         cmd_byte = unit_code(unit_idx[2:0]);
         if (cmd_code == CMD_OFF) begin
            cmd_byte = cmd_byte | OFF_FLAG;
         end
      end
   end

   // undefined command yields no frame
   assign load.go = take && (cmd_code != CMD_UNDEFINED);
   assign load.frame = {HEADER_HI, HEADER_LO, house_byte, cmd_byte, FOOTER};

endmodule

`default_nettype wire

### rtl/x10rf_shifter.sv
`default_nettype none

module x10rf_shifter
   import x10rf_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire load_type load,
   output logic idle,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output logic [1:0] rsp_symbol_kind,
   output logic rsp_bit_value,
   output logic rsp_last_symbol
);

   ser_state_type state_ff, state_in;
   logic [FRAME_BITS-1:0] shift_ff, shift_in;
   logic [SYM_COUNT_W-1:0] count_ff, count_in;
   logic valid_ff, valid_in;
   logic [1:0] kind_ff, kind_in;
   logic bit_ff, bit_in;
   logic last_ff, last_in;
   logic slot_free;

   assign slot_free = !valid_ff || rsp_ready;

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SER_IDLE;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      kind_ff <= kind_in;
      bit_ff <= bit_in;
      last_ff <= last_in;
   end

   // sequence ready pulse, frame bits and closing pause
   always_comb begin
      state_in = state_ff;
      shift_in = shift_ff;
      count_in = count_ff;
      kind_in = kind_ff;
      bit_in = bit_ff;
      last_in = last_ff;
      valid_in = valid_ff && !rsp_ready;
      case (state_ff)
         SER_IDLE: begin
            if (load.go) begin
               shift_in = load.frame;
               count_in = '0;
               state_in = SER_SEND;
            end
         end
         SER_SEND: begin
            if (slot_free) begin
               valid_in = 1'b1;
               bit_in = 1'b0;
               last_in = 1'b0;
               if (count_ff == '0) begin
                  kind_in = KIND_READY;
               end else if (count_ff == SYM_LAST) begin
                  kind_in = KIND_PAUSE;
                  last_in = 1'b1;
                  state_in = SER_IDLE;
               end else begin
                  // send MSB first, advance one bit
                  kind_in = KIND_DATA;
                  bit_in = shift_ff[FRAME_BITS-1];
                  shift_in = {shift_ff[FRAME_BITS-2:0], 1'b0};
               end
               count_in = count_ff + 1'b1;
            end
         end
         default: begin
            state_in = SER_IDLE;
         end
      endcase
   end

   assign idle = (state_ff == SER_IDLE);
   assign rsp_valid = valid_ff;
   assign rsp_symbol_kind = kind_ff;
   assign rsp_bit_value = bit_ff;
   assign rsp_last_symbol = last_ff;

endmodule

`default_nettype wire

### rtl/x10_rf_frame_serializer.sv
`default_nettype none

// RF command frame serializer for powerline home-control remote transmitters.
// Each accepted word (house index, unit, command) produces 42 output words:
// one ready pulse, the 40 frame bits MSB first (header D5 AA, house byte,
// command byte, footer AD) and a closing pause flagged by last_symbol.
// Command code 7 is accepted and dropped with no output. Output words leave
// one per cycle when the output is not stalled, from a 40-bit shift
// register; a command occupies the block, output stalls included, and the
// next request is taken once the closing pause has been registered. The
// two hold-time registers at byte addresses 0 and 4 are stored and read
// back for the downstream pin driver; they do not alter the output words.
module x10_rf_frame_serializer
   import x10rf_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire logic [3:0] req_house_index,
   input wire logic [4:0] req_unit_number,
   input wire logic [2:0] req_cmd,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output logic [1:0] rsp_symbol_kind,
   output logic rsp_bit_value,
   output logic rsp_last_symbol,
   input wire logic csr_psel,
   input wire logic csr_penable,
   input wire logic csr_pwrite,
   input wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input wire logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);

   logic [HOLD_W-1:0] bit_hold_ff, bit_hold_in;
   logic [HOLD_W-1:0] ready_hold_ff, ready_hold_in;
   logic csr_write;
   csr_index_type csr_idx;
   load_type load;
   logic idle;

   // register file
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx = csr_index_type'(csr_paddr[2]);

   always_comb begin
      bit_hold_in = bit_hold_ff;
      ready_hold_in = ready_hold_ff;
      if (csr_write) begin
         case (csr_idx)
            CSR_BIT_HOLD: bit_hold_in = csr_pwdata[HOLD_W-1:0];
            CSR_READY_HOLD: ready_hold_in = csr_pwdata[HOLD_W-1:0];
            default: begin
               bit_hold_in = bit_hold_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_hold_ff <= BIT_HOLD_RESET;
         ready_hold_ff <= READY_HOLD_RESET;
      end else begin
         bit_hold_ff <= bit_hold_in;
         ready_hold_ff <= ready_hold_in;
      end
   end

   // read back
   always_comb begin
      case (csr_idx)
         CSR_BIT_HOLD: csr_prdata = {8'd0, bit_hold_ff};
         CSR_READY_HOLD: csr_prdata = {8'd0, ready_hold_ff};
         default: csr_prdata = '0;
      endcase
   end

   assign req_ready = idle;

   x10rf_frame_build u_build (
      .take(req_valid && req_ready),
      .house_index(req_house_index),
      .unit_number(req_unit_number),
      .cmd(req_cmd),
      .load(load)
   );

   x10rf_shifter u_shifter (
      .clock(clock),
      .reset(reset),
      .load(load),
      .idle(idle),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_symbol_kind(rsp_symbol_kind),
      .rsp_bit_value(rsp_bit_value),
      .rsp_last_symbol(rsp_last_symbol)
   );

endmodule

`default_nettype wire
